/* design/euler_pose_to_affine_matrix_core_assert.svh */
// Assertion macros for the pose-to-matrix block
`ifndef EULER_POSE_TO_AFFINE_MATRIX_CORE_ASSERT_SVH
`define EULER_POSE_TO_AFFINE_MATRIX_CORE_ASSERT_SVH
// implication checked on every clock unless in reset
`define EPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define EPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/epa_pkg.sv */
// Package: widths, CORDIC constants and shared types for the pose-to-matrix block
package epa_pkg;
    localparam int PosW    = 32;
    localparam int AngW    = 16;
    localparam int MatW    = 16;
    localparam int ZW      = 24;
    localparam int XW      = 28;
    localparam int Steps   = 18;
    localparam logic signed [ZW-1:0] AngPi     = 24'sd3294199;
    localparam logic signed [ZW-1:0] AngHalfPi = 24'sd1647099;
    localparam logic signed [XW-1:0] CordicGain = 28'sd10188014;
    localparam logic signed [MatW-1:0] QOne = 16'sd16384;

    typedef logic signed [XW-1:0] xy_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic signed [AngW-1:0] angle_x;
        logic signed [AngW-1:0] angle_y;
        logic signed [AngW-1:0] angle_z;
    } pose_t;

    typedef struct packed {
        logic signed [MatW-1:0] m00;
        logic signed [MatW-1:0] m01;
        logic signed [MatW-1:0] m02;
        logic signed [MatW-1:0] m10;
        logic signed [MatW-1:0] m11;
        logic signed [MatW-1:0] m12;
        logic signed [MatW-1:0] m20;
        logic signed [MatW-1:0] m21;
        logic signed [MatW-1:0] m22;
        logic signed [PosW-1:0] tx;
        logic signed [PosW-1:0] ty;
        logic signed [PosW-1:0] tz;
    } mat_t;

    // one CORDIC lane as it moves between cells
    typedef struct packed {
        xy_t  x;
        xy_t  y;
        ang_t z;
        logic flip;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] lane;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
    } cell_data_t;

    function automatic ang_t atan_entry(input int i);
        ang_t r;
        unique case (i)
            0: r = 24'sd823550;   1: r = 24'sd486170;   2: r = 24'sd256879;
            3: r = 24'sd130396;   4: r = 24'sd65451;    5: r = 24'sd32757;
            6: r = 24'sd16383;    7: r = 24'sd8192;     8: r = 24'sd4096;
            9: r = 24'sd2048;     10: r = 24'sd1024;    11: r = 24'sd512;
            12: r = 24'sd256;     13: r = 24'sd128;     14: r = 24'sd64;
            15: r = 24'sd32;      16: r = 24'sd16;      default: r = 24'sd8;
        endcase
        return r;
    endfunction

    function automatic logic signed [MatW-1:0] sat_q14(input logic signed [31:0] v);
        logic signed [MatW-1:0] r;
        if (v > 32'sd16384)
            r = QOne;
        else if (v < -32'sd16384)
            r = -QOne;
        else
            r = v[MatW-1:0];
        return r;
    endfunction
endpackage

/* design/epa_stream_if.sv */
// Interface: valid/ready channel carrying one payload beat
interface epa_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/epa_cordic_cell.sv */
// CORDIC cell: one micro-rotation on each of three lanes, position carried along
module epa_cordic_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [4:0]             step,
    input  logic                   vin,
    input  epa_pkg::cell_data_t    din,
    output logic                   vout,
    output epa_pkg::cell_data_t    dout
);
    epa_pkg::cell_data_t data_next;
    epa_pkg::cell_data_t data_reg;
    logic                valid_reg;

    always_comb
    begin
        data_next = din;
        for (int l = 0; l < 3; l++)
        begin
            if (din.lane[l].z >= 0)
            begin
                data_next.lane[l].x = din.lane[l].x - (din.lane[l].y >>> step);
                data_next.lane[l].y = din.lane[l].y + (din.lane[l].x >>> step);
                data_next.lane[l].z = din.lane[l].z - epa_pkg::atan_entry(int'(step));
            end
            else
            begin
                data_next.lane[l].x = din.lane[l].x + (din.lane[l].y >>> step);
                data_next.lane[l].y = din.lane[l].y - (din.lane[l].x >>> step);
                data_next.lane[l].z = din.lane[l].z + epa_pkg::atan_entry(int'(step));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign vout = valid_reg;
    assign dout = data_reg;
endmodule

/* design/epa_matrix.sv */
// Matrix back end: rounding of sine/cosine, products and entry rounding, four stages
module epa_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vin,
    input  epa_pkg::cell_data_t din,
    output logic                vout,
    output epa_pkg::mat_t       dout
);
    typedef logic signed [epa_pkg::MatW-1:0] q14_t;
    typedef logic signed [31:0] p_t;
    typedef logic signed [47:0] w_t;

    q14_t s_next [3], c_next [3];
    q14_t s_reg [3], c_reg [3];
    logic signed [epa_pkg::PosW-1:0] p1_reg [3], p2_reg [3], p3_reg [3], p4_reg [3];
    logic [3:0] v_reg;

    p_t sysz_reg, sycz_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    p_t sxsz_reg, cxsz_reg, sxcz_reg, cxcz_reg;
    q14_t sx2_reg, cx2_reg, sy2_reg;

    w_t e_next [9];
    w_t e_reg [9];
    q14_t m_reg [9];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            q14_t cs;
            q14_t sn;
            cs = epa_pkg::sat_q14(32'(din.lane[l].x + 28'sd512) >>> 10);
            sn = epa_pkg::sat_q14(32'(din.lane[l].y + 28'sd512) >>> 10);
            c_next[l] = din.lane[l].flip ? -cs : cs;
            s_next[l] = din.lane[l].flip ? -sn : sn;
        end
    end

    always_comb
    begin
        e_next[0] = w_t'(cycz_reg) <<< 14;
        e_next[1] = w_t'(sx2_reg) * w_t'(sycz_reg) - (w_t'(cxsz_reg) <<< 14);
        e_next[2] = w_t'(cx2_reg) * w_t'(sycz_reg) + (w_t'(sxsz_reg) <<< 14);
        e_next[3] = w_t'(cysz_reg) <<< 14;
        e_next[4] = w_t'(sx2_reg) * w_t'(sysz_reg) + (w_t'(cxcz_reg) <<< 14);
        e_next[5] = w_t'(cx2_reg) * w_t'(sysz_reg) - (w_t'(sxcz_reg) <<< 14);
        e_next[6] = -(w_t'(sy2_reg) <<< 28);
        e_next[7] = w_t'(sxcy_reg) <<< 14;
        e_next[8] = w_t'(cxcy_reg) <<< 14;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], vin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
            p1_reg[0] <= din.pos_x;
            p1_reg[1] <= din.pos_y;
            p1_reg[2] <= din.pos_z;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            sysz_reg <= p_t'(s_reg[1]) * p_t'(s_reg[2]);
            sycz_reg <= p_t'(s_reg[1]) * p_t'(c_reg[2]);
            cycz_reg <= p_t'(c_reg[1]) * p_t'(c_reg[2]);
            cysz_reg <= p_t'(c_reg[1]) * p_t'(s_reg[2]);
            sxcy_reg <= p_t'(s_reg[0]) * p_t'(c_reg[1]);
            cxcy_reg <= p_t'(c_reg[0]) * p_t'(c_reg[1]);
            sxsz_reg <= p_t'(s_reg[0]) * p_t'(s_reg[2]);
            cxsz_reg <= p_t'(c_reg[0]) * p_t'(s_reg[2]);
            sxcz_reg <= p_t'(s_reg[0]) * p_t'(c_reg[2]);
            cxcz_reg <= p_t'(c_reg[0]) * p_t'(c_reg[2]);
            sx2_reg <= s_reg[0];
            cx2_reg <= c_reg[0];
            sy2_reg <= s_reg[1];
            e_reg <= e_next;
            for (int k = 0; k < 9; k++)
                m_reg[k] <= epa_pkg::sat_q14(32'((e_reg[k] + 48'sd134217728) >>> 28));
        end
    end

    assign vout = v_reg[3];
    assign dout.m00 = m_reg[0];
    assign dout.m01 = m_reg[1];
    assign dout.m02 = m_reg[2];
    assign dout.m10 = m_reg[3];
    assign dout.m11 = m_reg[4];
    assign dout.m12 = m_reg[5];
    assign dout.m20 = m_reg[6];
    assign dout.m21 = m_reg[7];
    assign dout.m22 = m_reg[8];
    assign dout.tx = p4_reg[0];
    assign dout.ty = p4_reg[1];
    assign dout.tz = p4_reg[2];
endmodule

/* design/euler_pose_to_affine_matrix_core.sv */
// Top level: Euler pose to 3x4 affine matrix, CORDIC cell chain plus matrix stages
//  channel | dir | payload
//  pose    | in  | pos_x/y/z Q16.16, angle_x/y/z Q3.13
//  matrix  | out | m00..m22 Q1.14, tx/ty/tz Q16.16
// One pose per cycle while the output register is not stalled;
// 24 register stages (reduction, 18 CORDIC cells, 4 matrix stages, output).
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears only valid bits.
module euler_pose_to_affine_matrix_core (
    input  logic clk,
    input  logic rst_n,
    epa_stream_if.sink   pose,
    epa_stream_if.source matrix
);
    localparam int N = epa_pkg::Steps;

    logic                en;
    logic                v  [N+1];
    epa_pkg::cell_data_t d  [N+1];
    epa_pkg::cell_data_t red_next;
    epa_pkg::cell_data_t red_reg;
    logic                red_v_reg;
    epa_pkg::mat_t       out_reg;
    logic                out_v_reg;
    epa_pkg::mat_t       mat_d;
    logic                mat_v;

    assign en = !out_v_reg || matrix.ready;
    assign pose.ready = en;

    always_comb
    begin
        logic signed [epa_pkg::AngW-1:0] a [3];
        epa_pkg::ang_t z;
        a[0] = pose.payload.angle_x;
        a[1] = pose.payload.angle_y;
        a[2] = pose.payload.angle_z;
        red_next.pos_x = pose.payload.pos_x;
        red_next.pos_y = pose.payload.pos_y;
        red_next.pos_z = pose.payload.pos_z;
        for (int l = 0; l < 3; l++)
        begin
            z = epa_pkg::ang_t'(a[l]) <<< 7;
            red_next.lane[l].x = epa_pkg::CordicGain;
            red_next.lane[l].y = '0;
            red_next.lane[l].flip = 1'b0;
            red_next.lane[l].z = z;
            if (z > epa_pkg::AngHalfPi)
            begin
                red_next.lane[l].z = z - epa_pkg::AngPi;
                red_next.lane[l].flip = 1'b1;
            end
            else if (z < -epa_pkg::AngHalfPi)
            begin
                red_next.lane[l].z = z + epa_pkg::AngPi;
                red_next.lane[l].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            red_v_reg <= 1'b0;
        else if (en)
            red_v_reg <= pose.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            red_reg <= red_next;
    end

    assign v[0] = red_v_reg;
    assign d[0] = red_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        epa_cordic_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .step (5'(i)),
            .vin  (v[i]),
            .din  (d[i]),
            .vout (v[i+1]),
            .dout (d[i+1])
        );
    end

    epa_matrix u_matrix (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (v[N]),
        .din  (d[N]),
        .vout (mat_v),
        .dout (mat_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= mat_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= mat_d;
    end

    assign matrix.valid = out_v_reg;
    assign matrix.payload = out_reg;
endmodule

/* design/epa_checker.sv */
// Checker: port-level properties of the pose-to-matrix block, bound to the top level
`include "euler_pose_to_affine_matrix_core_assert.svh"
module epa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input epa_pkg::mat_t out_payload
);
    logic m20_ok;
    logic stall;

    assign m20_ok = (out_payload.m20 <= epa_pkg::QOne) && (out_payload.m20 >= -epa_pkg::QOne);
    assign stall = out_valid && !out_ready;

    `EPA_ASSERT_IMPL(a_rot_range, clk, rst_n, out_valid, m20_ok)
    `EPA_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `EPA_ASSERT_NEXT(a_hold, clk, rst_n, stall, out_valid && $stable(out_payload))
endmodule

bind euler_pose_to_affine_matrix_core epa_checker u_epa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pose.ready),
    .out_valid  (matrix.valid),
    .out_ready  (matrix.ready),
    .out_payload(matrix.payload)
);

/* sim/euler_pose_to_affine_matrix_core_tb.sv */
// Testbench: random and directed poses checked against a bit-exact CORDIC matrix predictor
module euler_pose_to_affine_matrix_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    epa_stream_if #(.payload_t(epa_pkg::pose_t)) pose ();
    epa_stream_if #(.payload_t(epa_pkg::mat_t)) matrix ();

    euler_pose_to_affine_matrix_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .pose(pose.sink),
        .matrix(matrix.source)
    );

    epa_pkg::pose_t pending_poses[$];
    epa_pkg::mat_t expected_matrices[$];
    int errors = 0;
    bit stimulus_done = 1'b0;
    int hold_cycles = 0;
    bit hold_off = 1'b0;
    bit pose_taken = 1'b0;

    localparam longint GainQ24 = 10188014;
    localparam longint PiU = 3294199;
    localparam longint HalfPiU = 1647099;

    function automatic longint arctan_step(input int i);
        longint tab[18] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};
        return tab[i];
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function automatic void sine_cosine(input logic signed [15:0] ang, output longint s,
                                        output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        z = longint'(ang) * 128;
        x = GainQ24;
        y = 0;
        flip = 1'b0;
        if (z > HalfPiU)
        begin
            z -= PiU;
            flip = 1'b1;
        end
        else if (z < -HalfPiU)
        begin
            z += PiU;
            flip = 1'b1;
        end
        for (int i = 0; i < 18; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_step(i);
            end
        end
        x = clamp_unit((x + 512) >>> 10);
        y = clamp_unit((y + 512) >>> 10);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [15:0] round_entry(input longint v42);
        longint r;
        r = clamp_unit((v42 + (longint'(1) <<< 27)) >>> 28);
        return r[15:0];
    endfunction

    function automatic epa_pkg::mat_t pose_matrix(input epa_pkg::pose_t p);
        longint sx, cx, sy, cy, sz, cz;
        epa_pkg::mat_t m;
        sine_cosine(p.angle_x, sx, cx);
        sine_cosine(p.angle_y, sy, cy);
        sine_cosine(p.angle_z, sz, cz);
        m.m00 = round_entry(cy * cz * 16384);
        m.m01 = round_entry(sx * sy * cz - cx * sz * 16384);
        m.m02 = round_entry(cx * sy * cz + sx * sz * 16384);
        m.m10 = round_entry(cy * sz * 16384);
        m.m11 = round_entry(sx * sy * sz + cx * cz * 16384);
        m.m12 = round_entry(cx * sy * sz - sx * cz * 16384);
        m.m20 = round_entry(-sy * 16384 * 16384);
        m.m21 = round_entry(sx * cy * 16384);
        m.m22 = round_entry(cx * cy * 16384);
        m.tx = p.pos_x;
        m.ty = p.pos_y;
        m.tz = p.pos_z;
        return m;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] angle_pick();
        logic [15:0] specials[8] = '{16'h7fff, 16'h8000, 16'h0000, 16'h3244, 16'hcdbc,
                                     16'h3243, 16'h1922, 16'hffff};
        if ($urandom_range(0, 7) == 0)
            return specials[$urandom_range(0, 7)];
        return 16'($urandom());
    endfunction

    function automatic epa_pkg::pose_t pose_of(input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz, input logic [15:0] ax,
                                               input logic [15:0] ay, input logic [15:0] az);
        epa_pkg::pose_t p;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        p.angle_x = ax;
        p.angle_y = ay;
        p.angle_z = az;
        return p;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t %s exp %0d got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver
    int send_gap = 0;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose.valid <= 1'b0;
            pose.payload <= '0;
        end
        else if (pose.valid && !pose_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            pose.valid <= 1'b0;
        end
        else if (pending_poses.size() > 0)
        begin
            pose.payload <= pending_poses.pop_front();
            pose.valid <= 1'b1;
            send_gap <= gap_length();
        end
        else
            pose.valid <= 1'b0;
    end

    // accepted beats on the pose side carry their expectation
    always @(posedge clk)
    begin
        pose_taken <= rst_n && pose.valid && pose.ready;
        if (rst_n && pose.valid && pose.ready)
            expected_matrices.push_back(pose_matrix(pose.payload));
    end

    // receiver ready with gaps and one long hold-off
    int take_gap = 0;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matrix.ready <= 1'b0;
        else if (hold_off)
            matrix.ready <= 1'b0;
        else if (take_gap > 0)
        begin
            take_gap <= take_gap - 1;
            matrix.ready <= 1'b0;
        end
        else
        begin
            matrix.ready <= 1'b1;
            take_gap <= gap_length();
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_off <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        epa_pkg::mat_t want;
        epa_pkg::mat_t got;
        if (rst_n && matrix.valid && matrix.ready)
        begin
            got = matrix.payload;
            if (expected_matrices.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_matrices.pop_front();
                check_field("m00", want.m00, got.m00);
                check_field("m01", want.m01, got.m01);
                check_field("m02", want.m02, got.m02);
                check_field("m10", want.m10, got.m10);
                check_field("m11", want.m11, got.m11);
                check_field("m12", want.m12, got.m12);
                check_field("m20", want.m20, got.m20);
                check_field("m21", want.m21, got.m21);
                check_field("m22", want.m22, got.m22);
                check_field("tx", want.tx, got.tx);
                check_field("ty", want.ty, got.ty);
                check_field("tz", want.tz, got.tz);
            end
        end
    end

    initial
    begin
        pending_poses.push_back(pose_of(0, 0, 0, 16'h0000, 16'h0000, 16'h0000));
        pending_poses.push_back(pose_of(32'h7fffffff, 32'h80000000, 32'hffffffff,
                                        16'h7fff, 16'h8000, 16'h7fff));
        pending_poses.push_back(pose_of(32'h80000000, 32'h7fffffff, 32'h00000001,
                                        16'h8000, 16'h7fff, 16'h8000));
        pending_poses.push_back(pose_of(32'h55555555, 32'haaaaaaaa, 32'h12345678,
                                        16'h3243, 16'h3244, 16'hcdbc));
        pending_poses.push_back(pose_of(32'haaaaaaaa, 32'h55555555, 32'hedcba987,
                                        16'hcdbd, 16'hcdbc, 16'h3244));
        pending_poses.push_back(pose_of(1, 2, 3, 16'h1922, 16'he6de, 16'h0000));
        pending_poses.push_back(pose_of(4, 5, 6, 16'h0000, 16'h3243, 16'h0000));
        pending_poses.push_back(pose_of(7, 8, 9, 16'h0000, 16'hcdbd, 16'h1922));
        pending_poses.push_back(pose_of(10, 11, 12, 16'h6487, 16'h9b79, 16'hffff));
        pending_poses.push_back(pose_of(13, 14, 15, 16'h0001, 16'hffff, 16'h5000));
        for (int i = 0; i < 400; i++)
            pending_poses.push_back(pose_of($urandom(), $urandom(), $urandom(),
                                            angle_pick(), angle_pick(), angle_pick()));
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_poses.size() < 300);
        @(posedge clk);
        hold_off <= 1'b1;
        hold_cycles <= 200;
        wait (pending_poses.size() == 0);
        @(posedge clk);
        while (pose.valid)
            @(posedge clk);
        while (expected_matrices.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
